@@ rtl/mipmap_downsample_unit_macros.svh @@
// Assertion macros used by the mipmap downsample unit top level.
`ifndef MIPMAP_DOWNSAMPLE_UNIT_MACROS_SVH
`define MIPMAP_DOWNSAMPLE_UNIT_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define MDU_ASSERT_SAME(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define MDU_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

@@ rtl/mdu_pkg.sv @@
// Types and constants shared by the mipmap downsample unit modules.
package mdu_pkg;

  localparam int CRD_W    = 13;
  localparam int CHAN_W   = 8;
  localparam int NUM_CHAN = 4;
  localparam int PIX_W    = CHAN_W * NUM_CHAN;
  localparam int LOG_W    = 4;
  localparam int ACC_W    = 14;
  localparam int PROD_W   = 29;
  localparam int SHIFT_W  = 2;
  localparam int TAP_W    = 4;
  localparam int CFG_IDX_W = 2;

  // Reciprocal of 36 scaled by 2^19; exact for sums up to 36 * 255.
  localparam logic [14:0] DIV_MULT  = 15'd14564;
  localparam int          DIV_SHIFT = 19;
  localparam int          BOX_SHIFT  = 2;
  localparam int          PAIR_SHIFT = 1;

  localparam logic [TAP_W-1:0] LAST_TAP_FILTER = 4'd15;
  localparam logic [TAP_W-1:0] LAST_TAP_BOX    = 4'd3;
  localparam logic [TAP_W-1:0] LAST_TAP_PAIR   = 4'd1;

  localparam logic CMD_WRITE = 1'b0;
  localparam logic CMD_READ  = 1'b1;

  localparam logic [CFG_IDX_W-1:0] CFG_WIDTH_LOG2  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_HEIGHT_LOG2 = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_BOX_MODE    = 2'd2;

  typedef logic [CRD_W-1:0]   crd_t;
  typedef logic [2*CRD_W-1:0] addr_wide_t;
  typedef logic [ACC_W-1:0]   acc_t;
  typedef logic [PROD_W-1:0]  prod_t;
  typedef logic [CHAN_W-1:0]  chan_t;

  typedef enum logic [1:0] {
    KIND_FILTER,
    KIND_BOX,
    KIND_PAIR_COL,
    KIND_PAIR_ROW
  } kind_e;

  typedef struct packed {
    logic [LOG_W-1:0] width_log2;
    logic [LOG_W-1:0] height_log2;
    logic             box_mode;
  } cfg_t;

  localparam cfg_t CFG_RESET = '{width_log2: 4'd8, height_log2: 4'd8, box_mode: 1'b0};

  typedef struct packed {
    logic               clear;
    logic               add;
    logic [SHIFT_W-1:0] shift;
  } lane_ctl_t;

  typedef struct packed {
    logic  done;
    logic  in_range;
    kind_e kind;
  } rd_done_t;

endpackage

@@ rtl/mdu_ram.sv @@
// Generic single-port RAM with registered read data.
module mdu_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 65536
) (
  input  logic                                     clk_i,
  input  logic                                     we_i,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] addr_i,
  input  logic [WIDTH-1:0]                         wdata_i,
  output logic [WIDTH-1:0]                         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[addr_i] <= wdata_i;
    end
    rdata_q <= mem_q[addr_i];
  end

  assign rdata_o = rdata_q;

endmodule

@@ rtl/mdu_lane.sv @@
// One channel lane: accumulates weighted pixel samples for a read.
module mdu_lane (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  mdu_pkg::lane_ctl_t     ctl_i,
  input  mdu_pkg::chan_t         data_i,
  output mdu_pkg::acc_t          sum_o
);

  mdu_pkg::acc_t acc_q;
  mdu_pkg::acc_t acc_d;

  always_comb begin
    acc_d = acc_q;
    if (ctl_i.clear) begin
      acc_d = '0;
    end else if (ctl_i.add) begin
      acc_d = acc_q + (mdu_pkg::acc_t'(data_i) << ctl_i.shift);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      acc_q <= '0;
    end else begin
      acc_q <= acc_d;
    end
  end

  assign sum_o = acc_q;

endmodule

@@ rtl/mdu_ctrl.sv @@
// Command sequencer: stores pixels and walks the filter taps of a read.
module mdu_ctrl #(
  parameter int MAX_WIDTH  = 256,
  parameter int MAX_HEIGHT = 256
) (
  input  logic                                  clk_i,
  input  logic                                  rst_ni,
  input  logic                                  in_valid_i,
  output logic                                  in_ready_o,
  input  logic                                  command_i,
  input  logic [7:0]                            x_pos_i,
  input  logic [7:0]                            y_pos_i,
  input  logic [mdu_pkg::PIX_W-1:0]             pixel_i,
  input  mdu_pkg::cfg_t                         cfg_i,
  input  logic                                  mid_busy_i,
  output logic                                  ram_we_o,
  output logic [((MAX_WIDTH * MAX_HEIGHT > 1) ?
                 $clog2(MAX_WIDTH * MAX_HEIGHT) : 1)-1:0] ram_addr_o,
  output logic [mdu_pkg::PIX_W-1:0]             ram_wdata_o,
  output mdu_pkg::lane_ctl_t                    lane_ctl_o,
  output mdu_pkg::rd_done_t                     rd_done_o
);

  localparam int DEPTH     = MAX_WIDTH * MAX_HEIGHT;
  localparam int ADDR_W    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int W_LOG_MAX = $clog2(MAX_WIDTH + 1) - 1;
  localparam int H_LOG_MAX = $clog2(MAX_HEIGHT + 1) - 1;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_FETCH,
    ST_DRAIN
  } state_e;

  state_e                           state_q, state_d;
  logic                             done_q, done_d;
  logic                             rd_pend_q, rd_pend_d;
  logic [mdu_pkg::SHIFT_W-1:0]      shift_q, shift_d;
  logic [mdu_pkg::TAP_W-1:0]        tap_q, tap_d;
  logic                             range_q, range_d;
  mdu_pkg::kind_e                   kind_q, kind_d;
  mdu_pkg::crd_t                    base_x_q, base_x_d;
  mdu_pkg::crd_t                    base_y_q, base_y_d;
  mdu_pkg::crd_t                    mask_x_q, mask_x_d;
  mdu_pkg::crd_t                    mask_y_q, mask_y_d;

  logic [mdu_pkg::LOG_W-1:0]        wl, hl;
  mdu_pkg::crd_t                    w_size, h_size, half_w, half_h;
  mdu_pkg::crd_t                    x_ext, y_ext;
  logic                             rd_range;
  mdu_pkg::kind_e                   rd_kind;
  logic                             accept;
  logic                             in_store;
  logic [1:0]                       q_off, r_off;
  logic [mdu_pkg::TAP_W-1:0]        last_tap;
  logic [mdu_pkg::SHIFT_W-1:0]      tap_shift;
  logic                             q_inner, r_inner;
  mdu_pkg::crd_t                    sx, sy;
  logic [ADDR_W-1:0]                fetch_addr, wr_addr;

  always_comb begin
    wl = (cfg_i.width_log2 > mdu_pkg::LOG_W'(W_LOG_MAX)) ?
         mdu_pkg::LOG_W'(W_LOG_MAX) : cfg_i.width_log2;
    hl = (cfg_i.height_log2 > mdu_pkg::LOG_W'(H_LOG_MAX)) ?
         mdu_pkg::LOG_W'(H_LOG_MAX) : cfg_i.height_log2;
    w_size = mdu_pkg::crd_t'(1) << wl;
    h_size = mdu_pkg::crd_t'(1) << hl;
    half_w = w_size >> 1;
    half_h = h_size >> 1;
    x_ext  = mdu_pkg::crd_t'(x_pos_i);
    y_ext  = mdu_pkg::crd_t'(y_pos_i);

    if (wl == '0 && hl == '0) begin
      rd_range = 1'b0;
    end else if (wl == '0) begin
      rd_range = (x_ext == '0) && (y_ext < half_h);
    end else if (hl == '0) begin
      rd_range = (y_ext == '0) && (x_ext < half_w);
    end else begin
      rd_range = (x_ext < half_w) && (y_ext < half_h);
    end

    if (wl == '0) begin
      rd_kind = mdu_pkg::KIND_PAIR_COL;
    end else if (hl == '0) begin
      rd_kind = mdu_pkg::KIND_PAIR_ROW;
    end else if (cfg_i.box_mode) begin
      rd_kind = mdu_pkg::KIND_BOX;
    end else begin
      rd_kind = mdu_pkg::KIND_FILTER;
    end

    in_store = (x_ext < mdu_pkg::crd_t'(MAX_WIDTH)) && (y_ext < mdu_pkg::crd_t'(MAX_HEIGHT));
    wr_addr  = ADDR_W'(mdu_pkg::addr_wide_t'(y_ext) * mdu_pkg::addr_wide_t'(MAX_WIDTH) +
                       mdu_pkg::addr_wide_t'(x_ext));
  end

  always_comb begin
    case (kind_q)
      mdu_pkg::KIND_FILTER: begin
        q_off    = tap_q[1:0];
        r_off    = tap_q[3:2];
        last_tap = mdu_pkg::LAST_TAP_FILTER;
      end
      mdu_pkg::KIND_BOX: begin
        q_off    = {1'b0, tap_q[0]};
        r_off    = {1'b0, tap_q[1]};
        last_tap = mdu_pkg::LAST_TAP_BOX;
      end
      mdu_pkg::KIND_PAIR_COL: begin
        q_off    = 2'd0;
        r_off    = {1'b0, tap_q[0]};
        last_tap = mdu_pkg::LAST_TAP_PAIR;
      end
      mdu_pkg::KIND_PAIR_ROW: begin
        q_off    = {1'b0, tap_q[0]};
        r_off    = 2'd0;
        last_tap = mdu_pkg::LAST_TAP_PAIR;
      end
      default: begin
        q_off    = 2'd0;
        r_off    = 2'd0;
        last_tap = mdu_pkg::LAST_TAP_PAIR;
      end
    endcase

    // Inner taps of the 1-2-2-1 kernel carry weight two in each direction.
    q_inner   = (q_off == 2'd1) || (q_off == 2'd2);
    r_inner   = (r_off == 2'd1) || (r_off == 2'd2);
    tap_shift = (kind_q == mdu_pkg::KIND_FILTER) ?
                ({1'b0, q_inner} + {1'b0, r_inner}) : '0;

    sx = (base_x_q + mdu_pkg::crd_t'(q_off)) & mask_x_q;
    sy = (base_y_q + mdu_pkg::crd_t'(r_off)) & mask_y_q;
    fetch_addr = ADDR_W'(mdu_pkg::addr_wide_t'(sy) * mdu_pkg::addr_wide_t'(MAX_WIDTH) +
                         mdu_pkg::addr_wide_t'(sx));
  end

  assign in_ready_o = (state_q == ST_IDLE) && !done_q && !mid_busy_i;
  assign accept     = in_valid_i && in_ready_o;

  always_comb begin
    state_d   = state_q;
    done_d    = 1'b0;
    rd_pend_d = 1'b0;
    shift_d   = shift_q;
    tap_d     = tap_q;
    range_d   = range_q;
    kind_d    = kind_q;
    base_x_d  = base_x_q;
    base_y_d  = base_y_q;
    mask_x_d  = mask_x_q;
    mask_y_d  = mask_y_q;
    case (state_q)
      ST_IDLE: begin
        if (accept && command_i == mdu_pkg::CMD_READ) begin
          range_d = rd_range;
          kind_d  = rd_kind;
          tap_d   = '0;
          if (rd_kind == mdu_pkg::KIND_FILTER) begin
            base_x_d = (x_ext << 1) + w_size - mdu_pkg::crd_t'(1);
            base_y_d = (y_ext << 1) + h_size - mdu_pkg::crd_t'(1);
            mask_x_d = w_size - mdu_pkg::crd_t'(1);
            mask_y_d = h_size - mdu_pkg::crd_t'(1);
          end else begin
            base_x_d = x_ext << 1;
            base_y_d = y_ext << 1;
            mask_x_d = '1;
            mask_y_d = '1;
          end
          state_d = rd_range ? ST_FETCH : ST_DRAIN;
        end
      end
      ST_FETCH: begin
        rd_pend_d = 1'b1;
        shift_d   = tap_shift;
        tap_d     = tap_q + 1'b1;
        if (tap_q == last_tap) begin
          state_d = ST_DRAIN;
        end
      end
      ST_DRAIN: begin
        done_d  = 1'b1;
        state_d = ST_IDLE;
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= ST_IDLE;
      done_q    <= 1'b0;
      rd_pend_q <= 1'b0;
      shift_q   <= '0;
      tap_q     <= '0;
      range_q   <= 1'b0;
      kind_q    <= mdu_pkg::KIND_FILTER;
      base_x_q  <= '0;
      base_y_q  <= '0;
      mask_x_q  <= '0;
      mask_y_q  <= '0;
    end else begin
      state_q   <= state_d;
      done_q    <= done_d;
      rd_pend_q <= rd_pend_d;
      shift_q   <= shift_d;
      tap_q     <= tap_d;
      range_q   <= range_d;
      kind_q    <= kind_d;
      base_x_q  <= base_x_d;
      base_y_q  <= base_y_d;
      mask_x_q  <= mask_x_d;
      mask_y_q  <= mask_y_d;
    end
  end

  assign ram_we_o    = accept && (command_i == mdu_pkg::CMD_WRITE) && in_store;
  assign ram_addr_o  = (state_q == ST_FETCH) ? fetch_addr : wr_addr;
  assign ram_wdata_o = pixel_i;

  assign lane_ctl_o.clear = accept && (command_i == mdu_pkg::CMD_READ);
  assign lane_ctl_o.add   = rd_pend_q;
  assign lane_ctl_o.shift = shift_q;

  assign rd_done_o.done     = done_q;
  assign rd_done_o.in_range = range_q;
  assign rd_done_o.kind     = kind_q;

endmodule

@@ rtl/mdu_merge.sv @@
// Merging stage: scales the lane sums and holds the result item.
module mdu_merge (
  input  logic                                              clk_i,
  input  logic                                              rst_ni,
  input  mdu_pkg::rd_done_t                                 done_i,
  input  logic [mdu_pkg::NUM_CHAN-1:0][mdu_pkg::ACC_W-1:0]  sum_i,
  output logic                                              mid_busy_o,
  output logic                                              out_valid_o,
  input  logic                                              out_ready_i,
  output logic [mdu_pkg::NUM_CHAN-1:0][mdu_pkg::CHAN_W-1:0] chan_o,
  output logic                                              in_range_o
);

  logic                                              mid_valid_q, mid_valid_d;
  logic [mdu_pkg::NUM_CHAN-1:0][mdu_pkg::PROD_W-1:0] mid_val_q, mid_val_d;
  mdu_pkg::kind_e                                    mid_kind_q, mid_kind_d;
  logic                                              mid_range_q, mid_range_d;
  logic                                              out_valid_q, out_valid_d;
  logic [mdu_pkg::NUM_CHAN-1:0][mdu_pkg::CHAN_W-1:0] out_chan_q, out_chan_d;
  logic                                              out_range_q, out_range_d;
  logic                                              out_load;

  always_comb begin
    out_load    = mid_valid_q && (!out_valid_q || out_ready_i);
    mid_val_d   = mid_val_q;
    mid_kind_d  = mid_kind_q;
    mid_range_d = mid_range_q;
    if (done_i.done) begin
      mid_kind_d  = done_i.kind;
      mid_range_d = done_i.in_range;
      for (int c = 0; c < mdu_pkg::NUM_CHAN; c++) begin
        if (done_i.kind == mdu_pkg::KIND_FILTER) begin
          mid_val_d[c] = mdu_pkg::prod_t'(sum_i[c]) * mdu_pkg::prod_t'(mdu_pkg::DIV_MULT);
        end else begin
          mid_val_d[c] = mdu_pkg::prod_t'(sum_i[c]);
        end
      end
    end
    mid_valid_d = done_i.done ? 1'b1 : (out_load ? 1'b0 : mid_valid_q);

    out_chan_d  = out_chan_q;
    out_range_d = out_range_q;
    if (out_load) begin
      out_range_d = mid_range_q;
      for (int c = 0; c < mdu_pkg::NUM_CHAN; c++) begin
        case (mid_kind_q)
          mdu_pkg::KIND_FILTER: out_chan_d[c] = mdu_pkg::chan_t'(mid_val_q[c] >> mdu_pkg::DIV_SHIFT);
          mdu_pkg::KIND_BOX:    out_chan_d[c] = mdu_pkg::chan_t'(mid_val_q[c] >> mdu_pkg::BOX_SHIFT);
          default:              out_chan_d[c] = mdu_pkg::chan_t'(mid_val_q[c] >> mdu_pkg::PAIR_SHIFT);
        endcase
        if (!mid_range_q) begin
          out_chan_d[c] = '0;
        end
      end
    end
    out_valid_d = out_load ? 1'b1 : (out_ready_i ? 1'b0 : out_valid_q);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mid_valid_q <= 1'b0;
      mid_val_q   <= '0;
      mid_kind_q  <= mdu_pkg::KIND_FILTER;
      mid_range_q <= 1'b0;
      out_valid_q <= 1'b0;
      out_chan_q  <= '0;
      out_range_q <= 1'b0;
    end else begin
      mid_valid_q <= mid_valid_d;
      mid_val_q   <= mid_val_d;
      mid_kind_q  <= mid_kind_d;
      mid_range_q <= mid_range_d;
      out_valid_q <= out_valid_d;
      out_chan_q  <= out_chan_d;
      out_range_q <= out_range_d;
    end
  end

  assign mid_busy_o  = mid_valid_q;
  assign out_valid_o = out_valid_q;
  assign chan_o      = out_chan_q;
  assign in_range_o  = out_range_q;

endmodule

@@ rtl/mipmap_downsample_unit.sv @@
// Top level of the mipmap downsample unit.
// The input channel carries write items, which store one RGBA8 source pixel,
// and read items, which return one pixel of the next mip level on the output
// channel. Configuration registers are written through a plain write port;
// the user must write them only while the block is idle; it is not enforced.
// A write item produces no result. A filtered read fetches sixteen pixels
// through the single port of the image memory, one per cycle, a box read
// four, a single row or column read two and a read outside the output level
// none. The pixels pass into the four channel lanes, which accumulate in
// parallel; the merge stage then divides filtered sums by 36, box sums by 4
// and row or column sums by 2. After a read, the next item is taken only
// once its result has left the middle register of the merge stage.
// The result sits in an output register; while the receiver stalls one more
// read can complete into the merge stage before the input channel blocks.
// Reset clears all control state and loads the configuration reset values.
// The image memory has no reset and must be written before it is read.
`include "mipmap_downsample_unit_macros.svh"

module mipmap_downsample_unit #(
  parameter int MAX_WIDTH  = 256,
  parameter int MAX_HEIGHT = 256
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            cfg_we_i,
  input  logic [mdu_pkg::CFG_IDX_W-1:0]   cfg_idx_i,
  input  logic [mdu_pkg::LOG_W-1:0]       cfg_wdata_i,
  input  logic                            in_valid_i,
  output logic                            in_ready_o,
  input  logic                            command_i,
  input  logic [7:0]                      x_pos_i,
  input  logic [7:0]                      y_pos_i,
  input  logic [7:0]                      in_red_i,
  input  logic [7:0]                      in_green_i,
  input  logic [7:0]                      in_blue_i,
  input  logic [7:0]                      in_alpha_i,
  output logic                            out_valid_o,
  input  logic                            out_ready_i,
  output logic [7:0]                      out_red_o,
  output logic [7:0]                      out_green_o,
  output logic [7:0]                      out_blue_o,
  output logic [7:0]                      out_alpha_o,
  output logic                            in_range_o
);

  localparam int DEPTH  = MAX_WIDTH * MAX_HEIGHT;
  localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;

  mdu_pkg::cfg_t                                     cfg_q, cfg_d;
  logic                                              ram_we;
  logic [ADDR_W-1:0]                                 ram_addr;
  logic [mdu_pkg::PIX_W-1:0]                         ram_wdata, ram_rdata;
  mdu_pkg::lane_ctl_t                                lane_ctl;
  mdu_pkg::rd_done_t                                 rd_done;
  logic                                              mid_busy;
  logic [mdu_pkg::NUM_CHAN-1:0][mdu_pkg::ACC_W-1:0]  sums;
  logic [mdu_pkg::NUM_CHAN-1:0][mdu_pkg::CHAN_W-1:0] out_chan;

  always_comb begin
    cfg_d = cfg_q;
    if (cfg_we_i) begin
      case (cfg_idx_i)
        mdu_pkg::CFG_WIDTH_LOG2:  cfg_d.width_log2  = cfg_wdata_i;
        mdu_pkg::CFG_HEIGHT_LOG2: cfg_d.height_log2 = cfg_wdata_i;
        mdu_pkg::CFG_BOX_MODE:    cfg_d.box_mode    = cfg_wdata_i[0];
        default:                  cfg_d = cfg_q;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q <= mdu_pkg::CFG_RESET;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  mdu_ctrl #(
    .MAX_WIDTH  (MAX_WIDTH),
    .MAX_HEIGHT (MAX_HEIGHT)
  ) u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .command_i   (command_i),
    .x_pos_i     (x_pos_i),
    .y_pos_i     (y_pos_i),
    .pixel_i     ({in_alpha_i, in_blue_i, in_green_i, in_red_i}),
    .cfg_i       (cfg_q),
    .mid_busy_i  (mid_busy),
    .ram_we_o    (ram_we),
    .ram_addr_o  (ram_addr),
    .ram_wdata_o (ram_wdata),
    .lane_ctl_o  (lane_ctl),
    .rd_done_o   (rd_done)
  );

  mdu_ram #(
    .WIDTH (mdu_pkg::PIX_W),
    .DEPTH (DEPTH)
  ) u_image_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .addr_i  (ram_addr),
    .wdata_i (ram_wdata),
    .rdata_o (ram_rdata)
  );

  for (genvar c = 0; c < mdu_pkg::NUM_CHAN; c++) begin : g_lane
    mdu_lane u_lane (
      .clk_i  (clk_i),
      .rst_ni (rst_ni),
      .ctl_i  (lane_ctl),
      .data_i (ram_rdata[c*mdu_pkg::CHAN_W +: mdu_pkg::CHAN_W]),
      .sum_o  (sums[c])
    );
  end

  mdu_merge u_merge (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .done_i      (rd_done),
    .sum_i       (sums),
    .mid_busy_o  (mid_busy),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .chan_o      (out_chan),
    .in_range_o  (in_range_o)
  );

  assign out_red_o   = out_chan[0];
  assign out_green_o = out_chan[1];
  assign out_blue_o  = out_chan[2];
  assign out_alpha_o = out_chan[3];

  `MDU_ASSERT_SAME(a_clear_not_add, lane_ctl.clear, !lane_ctl.add, "Lane cleared during accumulation.")
  `MDU_ASSERT_NEXT(a_done_fills_mid, rd_done.done, mid_busy, "Finished read was not captured.")
  `MDU_ASSERT_SAME(a_outside_zero, out_valid_o && !in_range_o, (out_red_o == 8'd0) && (out_green_o == 8'd0) && (out_blue_o == 8'd0) && (out_alpha_o == 8'd0), "Out-of-range result has nonzero channels.")

endmodule
